[hw/rtl/ptpid_pkg.sv]
`timescale 1ns / 1ps

package ptpid_pkg;

    localparam int COORD_BITS     = 10;
    localparam int INTEGRAL_BITS  = 24;
    localparam int GAIN_FRAC_BITS = 12;

    localparam int GAIN_BITS     = 16;
    localparam int ANGLE_BITS    = 9;
    localparam int CFG_DATA_BITS = 16;
    localparam int CFG_IDX_BITS  = 4;

    // s0 input, s1 error/integral, s2 products, s3 sum, s4 control
    localparam int PIPE_STAGES = 5;

    localparam int ERR_BITS     = COORD_BITS + 1;
    localparam int DERR_BITS    = COORD_BITS + 2;
    localparam int ACC_BITS     = INTEGRAL_BITS + 1;
    localparam int PROD_P_BITS  = GAIN_BITS + 1 + ERR_BITS;
    localparam int PROD_I_BITS  = GAIN_BITS + 1 + INTEGRAL_BITS;
    localparam int PROD_D_BITS  = GAIN_BITS + 1 + DERR_BITS;
    localparam int SUM_BITS     = PROD_I_BITS + 2;
    localparam int CTRL_BITS    = SUM_BITS - GAIN_FRAC_BITS;
    localparam int SAT_BITS     = ANGLE_BITS + 2;
    localparam int ANG_SUM_BITS = SAT_BITS + 1;

    localparam logic signed [INTEGRAL_BITS-1:0] INTEG_MAX =
        {1'b0, {(INTEGRAL_BITS-1){1'b1}}};
    localparam logic signed [INTEGRAL_BITS-1:0] INTEG_MIN =
        {1'b1, {(INTEGRAL_BITS-1){1'b0}}};
    localparam logic signed [SAT_BITS-1:0] SAT_MAX = {1'b0, {(SAT_BITS-1){1'b1}}};
    localparam logic signed [SAT_BITS-1:0] SAT_MIN = {1'b1, {(SAT_BITS-1){1'b0}}};

    localparam logic [GAIN_BITS-1:0]  RST_GAIN_P       = GAIN_BITS'(410);
    localparam logic [GAIN_BITS-1:0]  RST_GAIN_I       = GAIN_BITS'(41);
    localparam logic [GAIN_BITS-1:0]  RST_GAIN_D       = GAIN_BITS'(41);
    localparam logic [COORD_BITS-1:0] RST_TARGET_X     = COORD_BITS'(320);
    localparam logic [COORD_BITS-1:0] RST_TARGET_Y     = COORD_BITS'(240);
    localparam logic [ANGLE_BITS-1:0] RST_CENTER_ANGLE = ANGLE_BITS'(90);
    localparam logic [ANGLE_BITS-1:0] RST_MIN_ANGLE    = ANGLE_BITS'(0);
    localparam logic [ANGLE_BITS-1:0] RST_MAX_ANGLE    = ANGLE_BITS'(180);

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_GAIN_P       = 4'd0,
        CFG_GAIN_I       = 4'd1,
        CFG_GAIN_D       = 4'd2,
        CFG_TARGET_X     = 4'd3,
        CFG_TARGET_Y     = 4'd4,
        CFG_CENTER_ANGLE = 4'd5,
        CFG_MIN_ANGLE    = 4'd6,
        CFG_MAX_ANGLE    = 4'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [GAIN_BITS-1:0]  gain_p;
        logic [GAIN_BITS-1:0]  gain_i;
        logic [GAIN_BITS-1:0]  gain_d;
        logic [COORD_BITS-1:0] target_x;
        logic [COORD_BITS-1:0] target_y;
        logic [ANGLE_BITS-1:0] center_angle;
        logic [ANGLE_BITS-1:0] min_angle;
        logic [ANGLE_BITS-1:0] max_angle;
    } t_cfg;

    typedef struct packed {
        logic [COORD_BITS-1:0] meas_x;
        logic [COORD_BITS-1:0] meas_y;
    } t_in_item;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] pan_angle;
        logic [ANGLE_BITS-1:0] tilt_angle;
        logic                  pan_changed;
        logic                  tilt_changed;
    } t_out_item;

    typedef struct packed {
        logic adv;   // whole pipe moves one stage
        logic upd;   // a valid beat leaves s0: commit integral and error
    } t_axis_ctl;

endpackage

[hw/rtl/ptpid_cfg_regs.sv]
`timescale 1ns / 1ps

module ptpid_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [ptpid_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [ptpid_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output ptpid_pkg::t_cfg                      o_cfg
);
    import ptpid_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_p       <= RST_GAIN_P;
            r_cfg.gain_i       <= RST_GAIN_I;
            r_cfg.gain_d       <= RST_GAIN_D;
            r_cfg.target_x     <= RST_TARGET_X;
            r_cfg.target_y     <= RST_TARGET_Y;
            r_cfg.center_angle <= RST_CENTER_ANGLE;
            r_cfg.min_angle    <= RST_MIN_ANGLE;
            r_cfg.max_angle    <= RST_MAX_ANGLE;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_P:       r_cfg.gain_p       <= i_cfg_data[GAIN_BITS-1:0];
                CFG_GAIN_I:       r_cfg.gain_i       <= i_cfg_data[GAIN_BITS-1:0];
                CFG_GAIN_D:       r_cfg.gain_d       <= i_cfg_data[GAIN_BITS-1:0];
                CFG_TARGET_X:     r_cfg.target_x     <= i_cfg_data[COORD_BITS-1:0];
                CFG_TARGET_Y:     r_cfg.target_y     <= i_cfg_data[COORD_BITS-1:0];
                CFG_CENTER_ANGLE: r_cfg.center_angle <= i_cfg_data[ANGLE_BITS-1:0];
                CFG_MIN_ANGLE:    r_cfg.min_angle    <= i_cfg_data[ANGLE_BITS-1:0];
                CFG_MAX_ANGLE:    r_cfg.max_angle    <= i_cfg_data[ANGLE_BITS-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[hw/rtl/ptpid_axis.sv]
`timescale 1ns / 1ps

module ptpid_axis (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  ptpid_pkg::t_axis_ctl               i_ctl,
    input  logic [ptpid_pkg::COORD_BITS-1:0]   i_meas,
    input  logic [ptpid_pkg::COORD_BITS-1:0]   i_target,
    input  ptpid_pkg::t_cfg                    i_cfg,
    output logic [ptpid_pkg::ANGLE_BITS-1:0]   o_angle
);
    import ptpid_pkg::*;

    logic        [COORD_BITS-1:0]    r_meas;
    logic signed [ERR_BITS-1:0]      r_prev;
    logic signed [ERR_BITS-1:0]      n_err;
    logic signed [INTEGRAL_BITS-1:0] r_integ;
    logic signed [INTEGRAL_BITS-1:0] n_integ;
    logic signed [ACC_BITS-1:0]      w_acc_wide;
    logic signed [DERR_BITS-1:0]     r_derr;
    logic signed [DERR_BITS-1:0]     n_derr;
    logic signed [GAIN_BITS:0]       w_gp;
    logic signed [GAIN_BITS:0]       w_gi;
    logic signed [GAIN_BITS:0]       w_gd;
    logic signed [PROD_P_BITS-1:0]   r_prod_p;
    logic signed [PROD_P_BITS-1:0]   n_prod_p;
    logic signed [PROD_I_BITS-1:0]   r_prod_i;
    logic signed [PROD_I_BITS-1:0]   n_prod_i;
    logic signed [PROD_D_BITS-1:0]   r_prod_d;
    logic signed [PROD_D_BITS-1:0]   n_prod_d;
    logic signed [SUM_BITS-1:0]      r_sum;
    logic signed [SUM_BITS-1:0]      n_sum;
    logic signed [CTRL_BITS-1:0]     w_ctrl_trunc;
    logic signed [CTRL_BITS-1:0]     w_ctrl;
    logic                            w_round_up;
    logic                            w_fits;
    logic signed [SAT_BITS-1:0]      r_ctrl;
    logic signed [SAT_BITS-1:0]      n_ctrl;
    logic signed [ANG_SUM_BITS-1:0]  w_ang;
    logic signed [ANG_SUM_BITS-1:0]  w_center;
    logic signed [ANG_SUM_BITS-1:0]  w_max;
    logic signed [ANG_SUM_BITS-1:0]  w_min;
    logic signed [ANG_SUM_BITS-1:0]  w_hi_clamped;

    // s1: error, saturating integral, error difference
    always_comb begin
        n_err      = $signed({1'b0, r_meas}) - $signed({1'b0, i_target});
        w_acc_wide = ACC_BITS'(r_integ) + ACC_BITS'(n_err);
        if (w_acc_wide[ACC_BITS-1] != w_acc_wide[ACC_BITS-2]) begin
            n_integ = w_acc_wide[ACC_BITS-1] ? INTEG_MIN : INTEG_MAX;
        end else begin
            n_integ = w_acc_wide[INTEGRAL_BITS-1:0];
        end
        n_derr = DERR_BITS'(n_err) - DERR_BITS'(r_prev);
    end

    // s2: gain products; r_prev and r_integ hold the s1 beat's error and integral
    always_comb begin
        w_gp     = $signed({1'b0, i_cfg.gain_p});
        w_gi     = $signed({1'b0, i_cfg.gain_i});
        w_gd     = $signed({1'b0, i_cfg.gain_d});
        n_prod_p = PROD_P_BITS'(w_gp) * PROD_P_BITS'(r_prev);
        n_prod_i = PROD_I_BITS'(w_gi) * PROD_I_BITS'(r_integ);
        n_prod_d = PROD_D_BITS'(w_gd) * PROD_D_BITS'(r_derr);
    end

    // s3: sum of the three terms
    assign n_sum = SUM_BITS'(r_prod_p) + SUM_BITS'(r_prod_i) + SUM_BITS'(r_prod_d);

    // s4: drop fraction toward zero, then saturate to a range that still clamps correctly
    always_comb begin
        w_ctrl_trunc = CTRL_BITS'(r_sum >>> GAIN_FRAC_BITS);
        w_round_up   = r_sum[SUM_BITS-1] & (|r_sum[GAIN_FRAC_BITS-1:0]);
        w_ctrl       = w_ctrl_trunc + CTRL_BITS'(w_round_up);
        w_fits       = (&w_ctrl[CTRL_BITS-1:SAT_BITS-1]) | ~(|w_ctrl[CTRL_BITS-1:SAT_BITS-1]);
        if (w_fits) begin
            n_ctrl = w_ctrl[SAT_BITS-1:0];
        end else begin
            n_ctrl = w_ctrl[CTRL_BITS-1] ? SAT_MIN : SAT_MAX;
        end
    end

    // add center, clamp high then low so inverted limits give the minimum
    always_comb begin
        w_center     = $signed({{(ANG_SUM_BITS-ANGLE_BITS){1'b0}}, i_cfg.center_angle});
        w_max        = $signed({{(ANG_SUM_BITS-ANGLE_BITS){1'b0}}, i_cfg.max_angle});
        w_min        = $signed({{(ANG_SUM_BITS-ANGLE_BITS){1'b0}}, i_cfg.min_angle});
        w_ang        = ANG_SUM_BITS'(r_ctrl) + w_center;
        w_hi_clamped = (w_ang > w_max) ? w_max : w_ang;
        if (w_hi_clamped < w_min) begin
            o_angle = i_cfg.min_angle;
        end else begin
            o_angle = w_hi_clamped[ANGLE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_prev  <= '0;
        end else if (i_ctl.upd) begin
            r_integ <= n_integ;
            r_prev  <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv) begin
            r_meas   <= i_meas;
            r_derr   <= n_derr;
            r_prod_p <= n_prod_p;
            r_prod_i <= n_prod_i;
            r_prod_d <= n_prod_d;
            r_sum    <= n_sum;
            r_ctrl   <= n_ctrl;
        end
    end

    a_integ_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_ctl.upd |=> $stable(r_integ) && $stable(r_prev))
        else $error("integral state moved without an update");

    a_angle_limits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.min_angle <= i_cfg.max_angle
            |-> o_angle >= i_cfg.min_angle && o_angle <= i_cfg.max_angle)
        else $error("angle outside configured limits");

endmodule

[hw/rtl/pan_tilt_pid_servo_controller.sv]
`timescale 1ns / 1ps
// Two-axis PID position controller for a pan/tilt head.
// Input channel (i_in_valid / o_in_ready / i_in_data): one beat per frame with the
// measured target position meas_x, meas_y. Output channel (o_out_valid /
// i_out_ready / o_out_data): one beat per input beat with pan and tilt angles in
// degrees and a changed flag per axis against the last angle delivered.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index (0 gain_p,
// 1 gain_i, 2 gain_d, 3 target_x, 4 target_y, 5 center_angle, 6 min_angle,
// 7 max_angle); other indexes are ignored. Write only while the block is empty.
// Pipeline: an accepted beat passes the input stage, error/integral, multiply, sum,
// truncate/saturate, then the output register.
// Throughput: one beat per cycle unless stalled; integral and previous error are
// committed as a beat leaves the input stage, so consecutive beats need no spacing.
// Stall: all stages advance together only while the output register is empty or
// being taken; o_in_ready drops while a result sits untaken, and the whole pipe holds.
// Reset (synchronous, active low): registers return to their defaults, integral and
// previous error clear, the pipe empties, and the first result flags both axes changed.
module pan_tilt_pid_servo_controller (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  ptpid_pkg::t_in_item                  i_in_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output ptpid_pkg::t_out_item                 o_out_data,
    input  logic                                 i_cfg_we,
    input  logic [ptpid_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [ptpid_pkg::CFG_DATA_BITS-1:0]  i_cfg_data
);
    import ptpid_pkg::*;

    t_cfg                    w_cfg;
    t_axis_ctl               w_ctl;
    logic                    w_adv;
    logic                    w_out_load;
    logic [ANGLE_BITS-1:0]   w_pan;
    logic [ANGLE_BITS-1:0]   w_tilt;
    logic [PIPE_STAGES-1:0]  r_vld;
    logic                    r_out_valid;
    logic                    r_sent_valid;
    logic [ANGLE_BITS-1:0]   r_last_pan;
    logic [ANGLE_BITS-1:0]   r_last_tilt;
    t_out_item               r_out_data;
    t_out_item               n_out_data;

    ptpid_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    // advance when the output slot is free or drains this cycle
    assign w_adv      = !r_out_valid || i_out_ready;
    assign w_out_load = w_adv && r_vld[PIPE_STAGES-1];
    assign w_ctl.adv  = w_adv;
    assign w_ctl.upd  = w_adv && r_vld[0];

    ptpid_axis u_pan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_meas   (i_in_data.meas_x),
        .i_target (w_cfg.target_x),
        .i_cfg    (w_cfg),
        .o_angle  (w_pan)
    );

    ptpid_axis u_tilt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (w_ctl),
        .i_meas   (i_in_data.meas_y),
        .i_target (w_cfg.target_y),
        .i_cfg    (w_cfg),
        .o_angle  (w_tilt)
    );

    always_comb begin
        n_out_data.pan_angle    = w_pan;
        n_out_data.tilt_angle   = w_tilt;
        n_out_data.pan_changed  = !r_sent_valid || (w_pan != r_last_pan);
        n_out_data.tilt_changed = !r_sent_valid || (w_tilt != r_last_tilt);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld        <= '0;
            r_out_valid  <= 1'b0;
            r_sent_valid <= 1'b0;
            r_last_pan   <= '0;
            r_last_tilt  <= '0;
        end else if (w_adv) begin
            r_vld       <= {r_vld[PIPE_STAGES-2:0], i_in_valid};
            r_out_valid <= r_vld[PIPE_STAGES-1];
            if (r_vld[PIPE_STAGES-1]) begin
                r_sent_valid <= 1'b1;
                r_last_pan   <= w_pan;
                r_last_tilt  <= w_tilt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_in_ready  = w_adv;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    a_stall_holds_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !i_out_ready |=> $stable(r_vld))
        else $error("pipe moved while the output beat was stalled");

    a_first_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_sent_valid) |-> o_out_data.pan_changed && o_out_data.tilt_changed)
        else $error("first result after reset not flagged as changed");

    a_last_tracks_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(w_out_load) && $past(i_rst_n)
            |-> r_last_pan == o_out_data.pan_angle && r_last_tilt == o_out_data.tilt_angle)
        else $error("last sent angle differs from delivered beat");

endmodule

[verif/ptpid_angle_checker.sv]
`timescale 1ns / 1ps

module ptpid_angle_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  ptpid_pkg::t_in_item                  i_in_data,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  ptpid_pkg::t_out_item                 i_out_data,
    input  logic                                 i_cfg_we,
    input  logic [ptpid_pkg::CFG_IDX_BITS-1:0]   i_cfg_index,
    input  logic [ptpid_pkg::CFG_DATA_BITS-1:0]  i_cfg_data,
    output int                                   o_pending,
    output int                                   o_errors
);

    import ptpid_pkg::*;

    localparam int AXIS_PAN  = 0;
    localparam int AXIS_TILT = 1;

    t_cfg                  regs;
    longint                integ [2];
    longint                prev_err [2];
    logic [ANGLE_BITS-1:0] last_pan;
    logic [ANGLE_BITS-1:0] last_tilt;
    bit                    sent_any;
    t_out_item             angles_due [$];
    t_out_item             due;
    t_out_item             nxt;
    int                    errors;

    initial begin
        errors    = 0;
        o_errors  = 0;
        o_pending = 0;
    end

    function automatic logic [ANGLE_BITS-1:0] axis_angle(input int axis,
                                                         input logic [COORD_BITS-1:0] meas,
                                                         input logic [COORD_BITS-1:0] target);
        longint lim_hi;
        longint lim_lo;
        longint err;
        longint acc;
        longint sum;
        longint mag;
        longint ctrl;
        longint ang;
        lim_hi = (longint'(1) << (INTEGRAL_BITS - 1)) - 1;
        lim_lo = -lim_hi - 1;
        err = longint'(meas) - longint'(target);
        acc = integ[axis] + err;
        // hold the integral at the edge of its range
        if (acc > lim_hi) acc = lim_hi;
        if (acc < lim_lo) acc = lim_lo;
        integ[axis] = acc;
        sum = longint'(regs.gain_p) * err + longint'(regs.gain_i) * acc
            + longint'(regs.gain_d) * (err - prev_err[axis]);
        prev_err[axis] = err;
        // truncate toward zero, not toward minus infinity
        mag  = (sum < 0) ? -sum : sum;
        mag  = mag >>> GAIN_FRAC_BITS;
        ctrl = (sum < 0) ? -mag : mag;
        ang = longint'(regs.center_angle) + ctrl;
        if (ang > longint'(regs.max_angle)) ang = longint'(regs.max_angle);
        if (ang < longint'(regs.min_angle)) ang = longint'(regs.min_angle);
        return ANGLE_BITS'(ang);
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            regs.gain_p       = RST_GAIN_P;
            regs.gain_i       = RST_GAIN_I;
            regs.gain_d       = RST_GAIN_D;
            regs.target_x     = RST_TARGET_X;
            regs.target_y     = RST_TARGET_Y;
            regs.center_angle = RST_CENTER_ANGLE;
            regs.min_angle    = RST_MIN_ANGLE;
            regs.max_angle    = RST_MAX_ANGLE;
            integ[AXIS_PAN]     = 0;
            integ[AXIS_TILT]    = 0;
            prev_err[AXIS_PAN]  = 0;
            prev_err[AXIS_TILT] = 0;
            last_pan  = '0;
            last_tilt = '0;
            sent_any  = 1'b0;
            angles_due.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_GAIN_P:       regs.gain_p       = i_cfg_data[GAIN_BITS-1:0];
                    CFG_GAIN_I:       regs.gain_i       = i_cfg_data[GAIN_BITS-1:0];
                    CFG_GAIN_D:       regs.gain_d       = i_cfg_data[GAIN_BITS-1:0];
                    CFG_TARGET_X:     regs.target_x     = i_cfg_data[COORD_BITS-1:0];
                    CFG_TARGET_Y:     regs.target_y     = i_cfg_data[COORD_BITS-1:0];
                    CFG_CENTER_ANGLE: regs.center_angle = i_cfg_data[ANGLE_BITS-1:0];
                    CFG_MIN_ANGLE:    regs.min_angle    = i_cfg_data[ANGLE_BITS-1:0];
                    CFG_MAX_ANGLE:    regs.max_angle    = i_cfg_data[ANGLE_BITS-1:0];
                    default: ;
                endcase
            end

            if (i_out_valid && i_out_ready) begin
                if (angles_due.size() == 0) begin
                    if (errors < 10)
                        $display("angle beat with nothing outstanding: pan %0d tilt %0d",
                                 i_out_data.pan_angle, i_out_data.tilt_angle);
                    errors++;
                end else begin
                    due = angles_due.pop_front();
                    if (i_out_data.pan_angle !== due.pan_angle
                        || i_out_data.tilt_angle !== due.tilt_angle
                        || i_out_data.pan_changed !== due.pan_changed
                        || i_out_data.tilt_changed !== due.tilt_changed) begin
                        if (errors < 10)
                            $display("angle mismatch: expected pan %0d tilt %0d chg %b%b, got pan %0d tilt %0d chg %b%b",
                                     due.pan_angle, due.tilt_angle,
                                     due.pan_changed, due.tilt_changed,
                                     i_out_data.pan_angle, i_out_data.tilt_angle,
                                     i_out_data.pan_changed, i_out_data.tilt_changed);
                        errors++;
                    end
                end
            end

            if (i_in_valid && i_in_ready) begin
                nxt.pan_angle    = axis_angle(AXIS_PAN, i_in_data.meas_x, regs.target_x);
                nxt.tilt_angle   = axis_angle(AXIS_TILT, i_in_data.meas_y, regs.target_y);
                nxt.pan_changed  = !sent_any || (nxt.pan_angle != last_pan);
                nxt.tilt_changed = !sent_any || (nxt.tilt_angle != last_tilt);
                last_pan  = nxt.pan_angle;
                last_tilt = nxt.tilt_angle;
                sent_any  = 1'b1;
                angles_due.push_back(nxt);
            end
        end
        o_pending = angles_due.size();
        o_errors  = errors;
    end

endmodule

[verif/tb_pan_tilt_pid_servo_controller.sv]
`timescale 1ns / 1ps

module tb_pan_tilt_pid_servo_controller;

    import ptpid_pkg::*;

    localparam int  RAND_PHASES     = 5;
    localparam int  BEATS_PER_PHASE = 150;
    localparam int  DIRECTED_BEATS  = 19;
    localparam int  WINDUP_BEATS    = 40;
    localparam int  UNWIND_BEATS    = 40;
    localparam int  LONG_HOLD       = 300;
    localparam longint CYCLE_LIMIT  = 100000;

    logic                     clk;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_ready;
    t_in_item                 in_data;
    logic                     out_valid;
    logic                     out_ready;
    t_out_item                out_data;
    logic                     cfg_we;
    logic [CFG_IDX_BITS-1:0]  cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;
    int                       pending;
    int                       errors;
    longint                   cycles = 0;
    bit                       tx_eager = 1'b0;
    bit                       rx_eager = 1'b0;
    int                       tx_calm = 0;

    pan_tilt_pid_servo_controller i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    ptpid_angle_checker i_angle_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .o_pending   (pending),
        .o_errors    (errors)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic int next_gap();
        if (tx_eager) return 0;
        if (tx_calm > 0) begin
            tx_calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0) tx_calm = $urandom_range(10, 40);
        return $urandom_range(0, 12);
    endfunction

    function automatic logic [COORD_BITS-1:0] pick_coord(input logic [COORD_BITS-1:0] target,
                                                         input logic [COORD_BITS-1:0] prior);
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return prior;
            3, 4, 5: return target + COORD_BITS'($urandom_range(0, 16)) - COORD_BITS'(8);
            default: return COORD_BITS'($urandom);
        endcase
    endfunction

    // Enters right after an accepted beat (or when idle); leaves on the edge that takes it.
    task automatic send_beat(input logic [COORD_BITS-1:0] mx, input logic [COORD_BITS-1:0] my);
        int gap;
        gap = next_gap();
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid       <= 1'b1;
        in_data.meas_x <= mx;
        in_data.meas_y <= my;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (2 * PIPE_STAGES) @(negedge clk);
    endtask

    // Fill the bits above the register width with noise; the block must drop them.
    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input int width,
                             input logic [CFG_DATA_BITS-1:0] val);
        logic [CFG_DATA_BITS-1:0] mask;
        logic [CFG_DATA_BITS-1:0] noise;
        mask  = CFG_DATA_BITS'((32'd1 << width) - 1);
        noise = CFG_DATA_BITS'($urandom);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= (noise & ~mask) | (val & mask);
    endtask

    task automatic load_cfg(input t_cfg c);
        write_reg(CFG_GAIN_P, GAIN_BITS, c.gain_p);
        write_reg(CFG_GAIN_I, GAIN_BITS, c.gain_i);
        write_reg(CFG_GAIN_D, GAIN_BITS, c.gain_d);
        write_reg(CFG_TARGET_X, COORD_BITS, c.target_x);
        write_reg(CFG_TARGET_Y, COORD_BITS, c.target_y);
        write_reg(CFG_CENTER_ANGLE, ANGLE_BITS, c.center_angle);
        write_reg(CFG_MIN_ANGLE, ANGLE_BITS, c.min_angle);
        write_reg(CFG_MAX_ANGLE, ANGLE_BITS, c.max_angle);
        // unused index: must leave every register alone
        write_reg(CFG_IDX_BITS'(int'(CFG_MAX_ANGLE) + $urandom_range(1, 8)), CFG_DATA_BITS,
                  CFG_DATA_BITS'($urandom));
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    initial begin
        int stall;
        int done;
        int calm;
        int hold_at;
        out_ready = 1'b0;
        done      = 0;
        calm      = 0;
        hold_at   = DIRECTED_BEATS + BEATS_PER_PHASE + 40 + $urandom_range(0, 80);
        wait (rst_n);
        forever begin
            if (rx_eager || calm > 0) stall = 0;
            else stall = $urandom_range(0, 12);
            if (calm > 0) calm--;
            else if ($urandom_range(0, 24) == 0) calm = $urandom_range(10, 40);
            // one long hold-off so the pipe backs up into the input
            if (done == hold_at) stall = LONG_HOLD;
            @(negedge clk);
            if (stall > 0) begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            done++;
        end
    end

    initial begin
        t_cfg                  c;
        int                    phase;
        int                    n;
        logic [COORD_BITS-1:0] mx;
        logic [COORD_BITS-1:0] my;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // reset settings: on target first, then repeats, no target and the corners
        send_beat(10'd320, 10'd240);
        send_beat(10'd320, 10'd240);
        send_beat(10'd0, 10'd0);
        send_beat(10'd0, 10'd0);
        send_beat(10'd1023, 10'd1023);
        send_beat(10'd1023, 10'd0);
        send_beat(10'd0, 10'd1023);
        send_beat(10'd321, 10'd241);
        send_beat(10'd319, 10'd239);
        send_beat(10'd1023, 10'd1023);
        send_beat(10'd1023, 10'd1023);
        send_beat(10'd512, 10'd512);
        drain();

        // every gain at full scale, limits wide open
        c.gain_p       = '1;
        c.gain_i       = '1;
        c.gain_d       = '1;
        c.target_x     = '1;
        c.target_y     = '0;
        c.center_angle = '1;
        c.min_angle    = '0;
        c.max_angle    = '1;
        load_cfg(c);
        send_beat(10'd0, 10'd1023);
        send_beat(10'd1023, 10'd0);
        send_beat(10'd0, 10'd0);
        send_beat(10'd1023, 10'd1023);
        drain();

        // min above max: every angle lands on min
        c.gain_p    = RST_GAIN_P;
        c.gain_i    = RST_GAIN_I;
        c.gain_d    = RST_GAIN_D;
        c.target_x  = RST_TARGET_X;
        c.target_y  = RST_TARGET_Y;
        c.min_angle = ANGLE_BITS'(300);
        c.max_angle = ANGLE_BITS'(100);
        load_cfg(c);
        send_beat(10'd0, 10'd0);
        send_beat(10'd1023, 10'd1023);
        send_beat(10'd320, 10'd240);
        drain();

        mx = '0;
        my = '0;
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            c.gain_p       = GAIN_BITS'($urandom);
            c.gain_i       = GAIN_BITS'($urandom);
            c.gain_d       = GAIN_BITS'($urandom);
            c.target_x     = COORD_BITS'($urandom);
            c.target_y     = COORD_BITS'($urandom);
            c.center_angle = ANGLE_BITS'($urandom);
            c.min_angle    = ANGLE_BITS'($urandom);
            c.max_angle    = ANGLE_BITS'($urandom);
            case (phase)
                0: begin
                    c.gain_p    = GAIN_BITS'($urandom_range(0, 1023));
                    c.gain_i    = GAIN_BITS'($urandom_range(0, 127));
                    c.gain_d    = GAIN_BITS'($urandom_range(0, 1023));
                    c.min_angle = ANGLE_BITS'($urandom_range(0, 100));
                    c.max_angle = ANGLE_BITS'($urandom_range(150, 511));
                end
                1: begin
                    c.gain_p       = '1;
                    c.gain_i       = '1;
                    c.gain_d       = '1;
                    c.target_x     = '1;
                    c.target_y     = '1;
                    c.center_angle = '1;
                    c.min_angle    = '0;
                    c.max_angle    = '1;
                end
                2: begin
                    c.gain_p       = '0;
                    c.gain_i       = '0;
                    c.gain_d       = '0;
                    c.target_x     = '0;
                    c.target_y     = '0;
                    c.center_angle = '0;
                    c.min_angle    = '0;
                    c.max_angle    = '0;
                end
                3: begin
                    c.gain_p    = GAIN_BITS'($urandom_range(0, 2047));
                    c.gain_i    = GAIN_BITS'($urandom_range(0, 63));
                    c.gain_d    = GAIN_BITS'($urandom_range(0, 2047));
                    c.min_angle = ANGLE_BITS'($urandom_range(256, 511));
                    c.max_angle = ANGLE_BITS'($urandom_range(0, 255));
                end
                default: ;
            endcase
            load_cfg(c);
            for (n = 0; n < BEATS_PER_PHASE; n++) begin
                mx = pick_coord(c.target_x, mx);
                my = pick_coord(c.target_y, my);
                send_beat(mx, my);
            end
            drain();
        end

        // push the integrals one way at full error back to back, then the other way
        tx_eager       = 1'b1;
        rx_eager       = 1'b1;
        c.gain_p       = '0;
        c.gain_i       = GAIN_BITS'(1);
        c.gain_d       = '0;
        c.target_x     = '0;
        c.target_y     = '1;
        c.center_angle = ANGLE_BITS'(255);
        c.min_angle    = '0;
        c.max_angle    = '1;
        load_cfg(c);
        for (n = 0; n < WINDUP_BEATS; n++) send_beat('1, '0);
        drain();
        c.target_x = '1;
        c.target_y = '0;
        load_cfg(c);
        for (n = 0; n < UNWIND_BEATS; n++) send_beat('0, '1);
        drain();

        if (errors == 0 && pending == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
